[sv/vfv_pkg.sv]
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants for the voice frame validator.
// ----------------------------------------------------------------------------
package vfv_pkg;

  // sample word and fixed-point scaling
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RATE_FRAC   = 15;
  localparam int unsigned FRAC2       = 2 * (SAMPLE_BITS - 1);

  // 1e-6 in squared-sample units, rounded
  localparam longint unsigned EPS_SQ = ((64'd1 << FRAC2) + 64'd500000) / 64'd1000000;
  localparam int unsigned     EPS_W  = $clog2(EPS_SQ + 1);

  localparam int unsigned MAX_FRAME_DEF  = 1024;
  localparam int unsigned BG_MIN_FRAMES  = 10;
  localparam int unsigned CROSS_OUT_W    = 10;

  // port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W   = 64;
  localparam int unsigned S_USER_W   = 1;
  localparam int unsigned M_DATA_W   = 16;
  localparam int unsigned M_USER_W   = 4;

  // register reset values
  localparam logic [10:0] RST_FRAME_LENGTH = 11'd320;
  localparam logic [15:0] RST_ENERGY_MIN   = 16'd492;
  localparam logic [15:0] RST_RANGE_MIN    = 16'd262;
  localparam logic [14:0] RST_CROSS_MAX    = 15'd11469;
  localparam logic [14:0] RST_CROSS_MIN    = 15'd328;
  localparam logic [15:0] RST_HALF_RATIO   = 16'd26214;
  localparam logic [7:0]  RST_BG_FACTOR    = 8'd56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH = 3'd0,
    CFG_ENERGY_MIN   = 3'd1,
    CFG_RANGE_MIN    = 3'd2,
    CFG_CROSS_MAX    = 3'd3,
    CFG_CROSS_MIN    = 3'd4,
    CFG_HALF_RATIO   = 3'd5,
    CFG_BG_FACTOR    = 3'd6,
    CFG_ADAPTIVE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RSN_PASS        = 3'd0,
    RSN_NO_UPSTREAM = 3'd1,
    RSN_ENERGY      = 3'd2,
    RSN_RANGE       = 3'd3,
    RSN_CROSSINGS   = 3'd4,
    RSN_HIGH_HALF   = 3'd5,
    RSN_BACKGROUND  = 3'd6
  } reason_e;

  // frame-level side inputs, sampled with the last sample of a frame
  typedef struct packed {
    logic        upstream_voice;
    logic [15:0] frame_energy;
    logic [15:0] background_level;
    logic [15:0] background_count;
  } frame_info_t;

  // thresholds seen by the decision pipeline
  typedef struct packed {
    logic [15:0] energy_min;
    logic [15:0] range_min;
    logic [14:0] crossing_rate_max;
    logic [14:0] crossing_rate_min;
    logic [15:0] half_ratio_min;
    logic [7:0]  background_factor;
    logic        adaptive_enable;
  } cfg_t;

endpackage

[sv/vfv_front.sv]
// ----------------------------------------------------------------------------
// vfv_front
// Per-sample statistics: extremes, zero crossings, squared-sample half sums.
// ----------------------------------------------------------------------------
module vfv_front #(
  parameter int unsigned MAX_FRAME = vfv_pkg::MAX_FRAME_DEF,
  parameter int unsigned LEN_W     = $clog2(MAX_FRAME + 1),
  parameter int unsigned REC_W     = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_valid_i,
  output logic                                   s_ready_o,
  input  logic signed [vfv_pkg::SAMPLE_BITS-1:0] sample_i,
  input  vfv_pkg::frame_info_t                   info_i,
  input  logic [LEN_W-1:0]                       len_i,
  output logic                                   rec_valid_o,
  input  logic                                   rec_ready_i,
  output logic [REC_W-1:0]                       rec_o
);

  localparam int unsigned SB      = vfv_pkg::SAMPLE_BITS;
  localparam int unsigned IDX_W   = $clog2(MAX_FRAME);
  localparam int unsigned SQ_W    = 2 * SB - 1;
  localparam int unsigned EW      = SQ_W + LEN_W;
  localparam int unsigned RANGE_W = SB + 1;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // sample stage
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     prev_q, prev_d;
  logic signed [SB-1:0]     max_q, max_d, min_q, min_d;
  logic [IDX_W-1:0]         cnt_q, cnt_d;

  logic                     s_fire, nonneg, last, first_half, cross_inc;
  logic [LEN_W-1:0]         idx_ext;
  logic [IDX_W-1:0]         cnt_new;
  logic signed [SB-1:0]     max_new, min_new;
  logic [RANGE_W-1:0]       range_new;
  logic signed [2*SB-1:0]   sq_full;

  // square / accumulate stage
  logic                     p_v_q, p_v_d;
  logic                     p_last_q, p_first_q;
  logic [SQ_W-1:0]          p_sq_q;
  logic [RANGE_W-1:0]       p_range_q;
  logic [IDX_W-1:0]         p_cnt_q;
  vfv_pkg::frame_info_t     p_info_q;
  logic                     p_adv;

  logic [EW-1:0]            acc1_q, acc1_d, acc2_q, acc2_d;
  logic [EW-1:0]            sq_ext, add1, add2;

  assign s_fire = s_valid_i && s_ready_o;

  always_comb begin
    nonneg     = ~sample_i[SB-1];
    idx_ext    = LEN_W'(idx_q);
    last       = (idx_ext + LEN_W'(1)) >= len_i;
    first_half = idx_ext < (len_i >> 1);
    cross_inc  = (idx_q != '0) && (nonneg != prev_q);
    cnt_new    = cnt_q + IDX_W'(cross_inc);
    max_new    = (sample_i > max_q) ? sample_i : max_q;
    min_new    = (sample_i < min_q) ? sample_i : min_q;
    range_new  = {max_new[SB-1], max_new} - {min_new[SB-1], min_new};
    sq_full    = sample_i * sample_i;
  end

  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    max_d  = max_q;
    min_d  = min_q;
    cnt_d  = cnt_q;
    if (s_fire) begin
      if (last) begin
        idx_d  = '0;
        prev_d = 1'b0;
        max_d  = S_MIN;
        min_d  = S_MAX;
        cnt_d  = '0;
      end else begin
        idx_d  = idx_q + IDX_W'(1);
        prev_d = nonneg;
        max_d  = max_new;
        min_d  = min_new;
        cnt_d  = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      prev_q <= 1'b0;
      max_q  <= S_MIN;
      min_q  <= S_MAX;
      cnt_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      prev_q <= prev_d;
      max_q  <= max_d;
      min_q  <= min_d;
      cnt_q  <= cnt_d;
    end
  end

  // a frame end only stalls when the record queue is full
  assign p_adv       = !p_last_q || rec_ready_i;
  assign s_ready_o   = !p_v_q || p_adv;
  assign rec_valid_o = p_v_q && p_last_q;

  always_comb begin
    p_v_d = p_v_q;
    if (s_fire) begin
      p_v_d = 1'b1;
    end else if (p_adv) begin
      p_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q    <= 1'b0;
      p_last_q <= 1'b0;
    end else begin
      p_v_q <= p_v_d;
      if (s_fire) begin
        p_last_q <= last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      p_first_q <= first_half;
      p_sq_q    <= sq_full[SQ_W-1:0];
      p_range_q <= range_new;
      p_cnt_q   <= cnt_new;
      p_info_q  <= info_i;
    end
  end

  always_comb begin
    sq_ext = EW'(p_sq_q);
    add1   = acc1_q + (p_first_q ? sq_ext : '0);
    add2   = acc2_q + (p_first_q ? '0 : sq_ext);
    acc1_d = acc1_q;
    acc2_d = acc2_q;
    if (p_v_q && p_adv) begin
      acc1_d = p_last_q ? '0 : add1;
      acc2_d = p_last_q ? '0 : add2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else begin
      acc1_q <= acc1_d;
      acc2_q <= acc2_d;
    end
  end

  assign rec_o = {p_info_q, p_range_q, p_cnt_q, add1, add2};

  // a frame record waiting on a full queue is held, not dropped
  a_rec_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && !rec_ready_i |=> rec_valid_o && $stable(p_cnt_q) && $stable(acc1_q))
    else $error("frame record lost while stalled");

  a_idx_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && last |=> idx_q == '0 && cnt_q == '0)
    else $error("frame state not cleared at frame end");

endmodule

[sv/vfv_fifo.sv]
// ----------------------------------------------------------------------------
// vfv_fifo
// Two-entry queue for frame records between statistics and decision.
// ----------------------------------------------------------------------------
module vfv_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = cnt_q != 2'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH) && ((cnt_q == 2'(DEPTH)) || (cnt_q == '0) || (wr_ptr_q != rd_ptr_q)))
    else $error("queue fill and pointers disagree");

endmodule

[sv/vfv_back.sv]
// ----------------------------------------------------------------------------
// vfv_back
// Decision pipeline: scaled-product compares and reason priority.
// ----------------------------------------------------------------------------
module vfv_back #(
  parameter int unsigned MAX_FRAME = vfv_pkg::MAX_FRAME_DEF,
  parameter int unsigned LEN_W     = $clog2(MAX_FRAME + 1),
  parameter int unsigned REC_W     = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vfv_pkg::cfg_t                         cfg_i,
  input  logic [LEN_W-1:0]                      len_i,
  input  logic                                  rec_valid_i,
  output logic                                  rec_ready_o,
  input  logic [REC_W-1:0]                      rec_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output vfv_pkg::reason_e                      reason_o,
  output logic [vfv_pkg::CROSS_OUT_W-1:0]       crossings_o
);

  localparam int unsigned SB      = vfv_pkg::SAMPLE_BITS;
  localparam int unsigned IDX_W   = $clog2(MAX_FRAME);
  localparam int unsigned EW      = 2 * SB - 1 + LEN_W;
  localparam int unsigned RANGE_W = SB + 1;
  localparam int unsigned CR_W    = vfv_pkg::RATE_FRAC + LEN_W;
  localparam int unsigned SPLIT   = (EW + 1) / 2;
  localparam int unsigned HI_W    = EW - SPLIT;
  localparam int unsigned LO_PW   = SPLIT + 16;
  localparam int unsigned HI_PW   = HI_W + 16;
  localparam int unsigned EPS_PW  = vfv_pkg::EPS_W + 16;
  localparam int unsigned HALF_W  = EW + 17;
  localparam int unsigned BG_W    = 24;

  // record fields
  vfv_pkg::frame_info_t  r_info;
  logic [RANGE_W-1:0]    r_range;
  logic [IDX_W-1:0]      r_cnt;
  logic [EW-1:0]         r_first, r_second;

  logic adv;

  // stage 1: products and simple compares
  logic               c1_v_q;
  logic               c1_no_up_q, c1_low_e_q, c1_small_r_q, c1_bg_en_q;
  logic [IDX_W-1:0]   c1_cnt_q;
  logic [EW-1:0]      c1_first_q;
  logic [15:0]        c1_energy_q;
  logic [CR_W-1:0]    c1_crmax_q, c1_crmin_q;
  logic [LO_PW-1:0]   c1_p_lo_q;
  logic [HI_PW-1:0]   c1_p_hi_q;
  logic [EPS_PW-1:0]  c1_p_eps_q;
  logic [BG_W-1:0]    c1_bg_q;

  // stage 2: sums and rate/background compares
  logic               c2_v_q;
  logic               c2_no_up_q, c2_low_e_q, c2_small_r_q, c2_cross_bad_q, c2_bg_bad_q;
  logic [IDX_W-1:0]   c2_cnt_q;
  logic [HALF_W-1:0]  c2_lhs_q, c2_rhs_q;
  logic [CR_W-1:0]    cross_scaled;

  // result register
  logic               out_v_q;
  vfv_pkg::reason_e   out_reason_q, reason_d;
  logic [IDX_W-1:0]   out_cnt_q;

  assign {r_info, r_range, r_cnt, r_first, r_second} = rec_i;

  assign adv         = !out_v_q || res_ready_i;
  assign rec_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q  <= 1'b0;
      c2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      c1_v_q  <= rec_valid_i;
      c2_v_q  <= c1_v_q;
      out_v_q <= c2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_no_up_q   <= !r_info.upstream_voice;
      c1_low_e_q   <= r_info.frame_energy < cfg_i.energy_min;
      c1_small_r_q <= r_range < RANGE_W'(cfg_i.range_min);
      c1_bg_en_q   <= cfg_i.adaptive_enable &&
                      (r_info.background_count > 16'(vfv_pkg::BG_MIN_FRAMES));
      c1_cnt_q     <= r_cnt;
      c1_first_q   <= r_first;
      c1_energy_q  <= r_info.frame_energy;
      c1_crmax_q   <= CR_W'(cfg_i.crossing_rate_max) * CR_W'(len_i);
      c1_crmin_q   <= CR_W'(cfg_i.crossing_rate_min) * CR_W'(len_i);
      c1_p_lo_q    <= LO_PW'(r_second[SPLIT-1:0]) * LO_PW'(cfg_i.half_ratio_min);
      c1_p_hi_q    <= HI_PW'(r_second[EW-1:SPLIT]) * HI_PW'(cfg_i.half_ratio_min);
      c1_p_eps_q   <= EPS_PW'(vfv_pkg::EPS_SQ) * EPS_PW'(cfg_i.half_ratio_min);
      c1_bg_q      <= BG_W'(r_info.background_level) * BG_W'(cfg_i.background_factor);
    end
  end

  assign cross_scaled = CR_W'(c1_cnt_q) << vfv_pkg::RATE_FRAC;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_no_up_q     <= c1_no_up_q;
      c2_low_e_q     <= c1_low_e_q;
      c2_small_r_q   <= c1_small_r_q;
      c2_cross_bad_q <= (cross_scaled > c1_crmax_q) || (cross_scaled < c1_crmin_q);
      c2_bg_bad_q    <= c1_bg_en_q && ((BG_W'(c1_energy_q) << 4) < c1_bg_q);
      c2_cnt_q       <= c1_cnt_q;
      c2_lhs_q       <= HALF_W'(c1_first_q) << vfv_pkg::RATE_FRAC;
      c2_rhs_q       <= (HALF_W'(c1_p_hi_q) << SPLIT) + HALF_W'(c1_p_lo_q)
                        + HALF_W'(c1_p_eps_q);
    end
  end

  // first failing check wins
  always_comb begin
    if (c2_no_up_q) begin
      reason_d = vfv_pkg::RSN_NO_UPSTREAM;
    end else if (c2_low_e_q) begin
      reason_d = vfv_pkg::RSN_ENERGY;
    end else if (c2_small_r_q) begin
      reason_d = vfv_pkg::RSN_RANGE;
    end else if (c2_cross_bad_q) begin
      reason_d = vfv_pkg::RSN_CROSSINGS;
    end else if (c2_lhs_q < c2_rhs_q) begin
      reason_d = vfv_pkg::RSN_HIGH_HALF;
    end else if (c2_bg_bad_q) begin
      reason_d = vfv_pkg::RSN_BACKGROUND;
    end else begin
      reason_d = vfv_pkg::RSN_PASS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_reason_q <= reason_d;
      out_cnt_q    <= c2_cnt_q;
    end
  end

  assign res_valid_o = out_v_q;
  assign reason_o    = out_reason_q;
  assign crossings_o = vfv_pkg::CROSS_OUT_W'(out_cnt_q);

  // a stalled result freezes the whole decision pipeline
  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_ready_i |=> out_v_q && $stable(c1_v_q) && $stable(c2_v_q))
    else $error("decision pipeline moved under stall");

endmodule

[sv/voice_frame_validator_core.sv]
// ----------------------------------------------------------------------------
// voice_frame_validator_core
// Frame-level voice plausibility check on a stream of Q1.15 samples.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Request moves                 Packing (low bit first)
// s_axis    in   one sample + frame side data   tdata: sample, frame_energy,
//                                               background_level, background_count;
//                                               tuser: upstream_voice
// m_axis    out  one decision per frame         tdata: crossings, zero pad;
//                                               tuser: is_voice, reject_reason
// cfg       in   one register write             index 0..7, data low bits used
//
// Cycles: one sample per clock sustained while no frame-end sample waits on a
// full record queue. A frame's decision passes the sample stage, the
// square/accumulate stage, then three stages of the decision pipeline
// (products, sums and compares, reason priority) and leaves the result register.
// Reset: control state and frame statistics are cleared, registers take
// their defaults; no clearing pass.
// Stalls: a held result stalls only the decision pipeline; a two-record queue
// absorbs it, and samples stop only when a frame-end sample meets a full queue.
//
module voice_frame_validator_core #(
  parameter int unsigned MAX_FRAME = vfv_pkg::MAX_FRAME_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] sample, [31:16] frame_energy, [47:32] background_level,
  // [63:48] background_count
  input  logic [vfv_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // [0] upstream_voice
  input  logic [vfv_pkg::S_USER_W-1:0]       s_axis_tuser,
  // decision stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] crossings, [15:10] zero
  output logic [vfv_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // [0] is_voice, [3:1] reject_reason
  output logic [vfv_pkg::M_USER_W-1:0]       m_axis_tuser,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vfv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SB      = vfv_pkg::SAMPLE_BITS;
  localparam int unsigned IDX_W   = $clog2(MAX_FRAME);
  localparam int unsigned LEN_W   = $clog2(MAX_FRAME + 1);
  localparam int unsigned EW      = 2 * SB - 1 + LEN_W;
  localparam int unsigned REC_W   = $bits(vfv_pkg::frame_info_t) + (SB + 1) + IDX_W + 2 * EW;

  // --------------------------------------------------------------------------
  // Register file. Writes are always taken; the user must write only while the block is idle, not enforced here.
  // --------------------------------------------------------------------------
  logic [10:0]          frame_length_q;
  vfv_pkg::cfg_t        cfg_q;
  logic                 cfg_fire;
  logic [LEN_W-1:0]     len;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q          <= vfv_pkg::RST_FRAME_LENGTH;
      cfg_q.energy_min        <= vfv_pkg::RST_ENERGY_MIN;
      cfg_q.range_min         <= vfv_pkg::RST_RANGE_MIN;
      cfg_q.crossing_rate_max <= vfv_pkg::RST_CROSS_MAX;
      cfg_q.crossing_rate_min <= vfv_pkg::RST_CROSS_MIN;
      cfg_q.half_ratio_min    <= vfv_pkg::RST_HALF_RATIO;
      cfg_q.background_factor <= vfv_pkg::RST_BG_FACTOR;
      cfg_q.adaptive_enable   <= 1'b0;
    end else if (cfg_fire) begin
      unique case (vfv_pkg::cfg_idx_e'(cfg_index_i))
        vfv_pkg::CFG_FRAME_LENGTH: frame_length_q          <= cfg_data_i[10:0];
        vfv_pkg::CFG_ENERGY_MIN:   cfg_q.energy_min        <= cfg_data_i;
        vfv_pkg::CFG_RANGE_MIN:    cfg_q.range_min         <= cfg_data_i;
        vfv_pkg::CFG_CROSS_MAX:    cfg_q.crossing_rate_max <= cfg_data_i[14:0];
        vfv_pkg::CFG_CROSS_MIN:    cfg_q.crossing_rate_min <= cfg_data_i[14:0];
        vfv_pkg::CFG_HALF_RATIO:   cfg_q.half_ratio_min    <= cfg_data_i;
        vfv_pkg::CFG_BG_FACTOR:    cfg_q.background_factor <= cfg_data_i[7:0];
        vfv_pkg::CFG_ADAPTIVE:     cfg_q.adaptive_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective frame length, clamped to [2, MAX_FRAME]
  always_comb begin
    if (frame_length_q < 11'd2) begin
      len = LEN_W'(2);
    end else if (32'(frame_length_q) > MAX_FRAME) begin
      len = LEN_W'(MAX_FRAME);
    end else begin
      len = LEN_W'(frame_length_q);
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  logic signed [SB-1:0]  sample;
  vfv_pkg::frame_info_t  info;

  assign sample                = s_axis_tdata[15:0];
  assign info.frame_energy     = s_axis_tdata[31:16];
  assign info.background_level = s_axis_tdata[47:32];
  assign info.background_count = s_axis_tdata[63:48];
  assign info.upstream_voice   = s_axis_tuser[0];

  // --------------------------------------------------------------------------
  // Front: statistics per sample, one record per frame into the queue
  // --------------------------------------------------------------------------
  logic             f_rec_valid, f_rec_ready;
  logic [REC_W-1:0] f_rec;
  logic             b_rec_valid, b_rec_ready;
  logic [REC_W-1:0] b_rec;

  vfv_front #(
    .MAX_FRAME (MAX_FRAME),
    .LEN_W     (LEN_W),
    .REC_W     (REC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .sample_i    (sample),
    .info_i      (info),
    .len_i       (len),
    .rec_valid_o (f_rec_valid),
    .rec_ready_i (f_rec_ready),
    .rec_o       (f_rec)
  );

  vfv_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_rec_valid),
    .in_ready_o  (f_rec_ready),
    .in_data_i   (f_rec),
    .out_valid_o (b_rec_valid),
    .out_ready_i (b_rec_ready),
    .out_data_o  (b_rec)
  );

  // --------------------------------------------------------------------------
  // Back: thresholds and reason code
  // --------------------------------------------------------------------------
  vfv_pkg::reason_e                  reason;
  logic [vfv_pkg::CROSS_OUT_W-1:0]   crossings;

  vfv_back #(
    .MAX_FRAME (MAX_FRAME),
    .LEN_W     (LEN_W),
    .REC_W     (REC_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .len_i       (len),
    .rec_valid_i (b_rec_valid),
    .rec_ready_o (b_rec_ready),
    .rec_i       (b_rec),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .reason_o    (reason),
    .crossings_o (crossings)
  );

  assign m_axis_tdata = vfv_pkg::M_DATA_W'(crossings);
  assign m_axis_tuser = {reason, reason == vfv_pkg::RSN_PASS};

endmodule
